// ===== rtl/qbs_pkg.sv =====
package qbs_pkg;

    // queue_index is 4 bits wide, so at most 16 slots are addressable
    localparam int QUEUE_SPACE = 16;

    typedef enum logic [2:0] {
        CMD_SET        = 3'd0,
        CMD_ENQUEUE    = 3'd1,
        CMD_DRAIN      = 3'd2,
        CMD_REMOVE     = 3'd3,
        CMD_COMPLETION = 3'd4,
        CMD_QUERY      = 3'd5
    } cmd_t;

    typedef struct packed {
        logic teardown_ok;
        logic complete;
        logic barrier_cleared;
        logic found;
        logic emit_packet;
    } result_t;

endpackage

// ===== rtl/queue_barrier_scoreboard.sv =====
// Barrier scoreboard over NUM_QUEUES queue slots. Each input transaction
// carries a command in tuser and the final set entry of an arming sequence
// in tlast; every input transaction yields exactly one result transaction.
// Throughput is one transaction per cycle unless a low m_axis_tready stalls
// the output; each result passes the input register, then the result
// register. Each transaction reads and updates one slot plus the armed flag
// and the waiting-queue count together, which is what fixes that rate. Queue
// indexes at or above NUM_QUEUES only report status.
module queue_barrier_scoreboard #(
    parameter int NUM_QUEUES  = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] queue_index, [19:4] pending_count, [83:20] sequence_id, [87:84] zero
    input  logic [87:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    // [2:0] command
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] emit_packet, [1] found, [2] barrier_cleared, [3] complete,
    // [4] teardown_ok, [7:5] zero
    output logic [7:0]  m_axis_tdata
);
    import qbs_pkg::*;

    logic        in_valid_reg;
    cmd_t        cmd_reg;
    logic [3:0]  queue_reg;
    logic [15:0] count_reg;
    logic        last_reg;
    logic [63:0] seq_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result;
    logic        advance;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            cmd_reg   <= cmd_t'(s_axis_tuser);
            queue_reg <= s_axis_tdata[3:0];
            count_reg <= s_axis_tdata[19:4];
            seq_reg   <= s_axis_tdata[83:20];
            last_reg  <= s_axis_tlast;
        end
        if (advance)
            result_reg <= result;
    end

    qbs_core #(
        .NUM_QUEUES  (NUM_QUEUES),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .command       (cmd_reg),
        .queue_index   (queue_reg),
        .pending_count (count_reg),
        .last_entry    (last_reg),
        .sequence_id   (seq_reg),
        .result        (result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, result_reg.teardown_ok, result_reg.complete,
                            result_reg.barrier_cleared, result_reg.found,
                            result_reg.emit_packet};

endmodule

// ===== rtl/qbs_core.sv =====
module qbs_core #(
    parameter int NUM_QUEUES  = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  qbs_pkg::cmd_t   command,
    input  logic [3:0]      queue_index,
    input  logic [15:0]     pending_count,
    input  logic            last_entry,
    input  logic [63:0]     sequence_id,
    output qbs_pkg::result_t result
);
    import qbs_pkg::*;

    localparam int SLOTS = (NUM_QUEUES < QUEUE_SPACE) ? NUM_QUEUES : QUEUE_SPACE;
    localparam int WQ_W  = $clog2(SLOTS + 1);

    logic                   armed_reg, armed_next;
    logic [WQ_W-1:0]        waiting_reg, waiting_next;
    logic [COUNT_WIDTH-1:0] count_reg [SLOTS];
    logic [SLOTS-1:0]       pin_valid_reg, pin_valid_next;
    logic [63:0]            pin_seq_reg [SLOTS];

    logic [SLOTS-1:0]       sel;
    logic                   hit;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic                   cur_pin;
    logic [63:0]            cur_seq;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [COUNT_WIDTH-1:0] count_dec;
    logic [WQ_W-1:0]        waiting_dec;
    logic                   count_we;
    logic [COUNT_WIDTH-1:0] count_wr;
    logic                   pin_set;
    logic                   pin_clr;
    logic                   emit;
    logic                   found;
    logic                   cleared;

    // one-hot slot select and readout of the addressed slot
    always_comb
    begin
        sel       = '0;
        cur_count = '0;
        cur_pin   = 1'b0;
        cur_seq   = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            sel[i] = (queue_index == 4'(i));
            if (sel[i])
            begin
                cur_count = count_reg[i];
                cur_pin   = pin_valid_reg[i];
                cur_seq   = pin_seq_reg[i];
            end
        end
        hit = |sel;
    end

    assign cnt         = COUNT_WIDTH'(pending_count);
    assign count_dec   = cur_count - 1'b1;
    assign waiting_dec = (waiting_reg != '0) ? waiting_reg - 1'b1 : waiting_reg;

    always_comb
    begin
        armed_next   = armed_reg;
        waiting_next = waiting_reg;
        count_we     = 1'b0;
        count_wr     = '0;
        pin_set      = 1'b0;
        pin_clr      = 1'b0;
        emit         = 1'b0;
        found        = 1'b0;
        cleared      = 1'b0;
        if (hit)
        begin
            case (command)
                CMD_SET:
                begin
                    armed_next = 1'b1;
                    if (cnt != '0)
                    begin
                        count_we = 1'b1;
                        count_wr = cnt;
                        if (cur_count == '0)
                            waiting_next = waiting_reg + 1'b1;
                    end
                    if (last_entry && waiting_next == '0)
                    begin
                        armed_next = 1'b0;
                        cleared    = 1'b1;
                    end
                end
                CMD_ENQUEUE:
                begin
                    if (armed_reg && !cur_pin)
                    begin
                        pin_set = 1'b1;
                        emit    = 1'b1;
                    end
                end
                CMD_DRAIN:
                begin
                    if (!armed_reg && cur_pin && sequence_id >= cur_seq)
                        pin_clr = 1'b1;
                end
                CMD_REMOVE:
                begin
                    pin_clr = 1'b1;
                    if (cur_count != '0)
                    begin
                        count_we     = 1'b1;
                        count_wr     = '0;
                        waiting_next = waiting_dec;
                        if (waiting_dec == '0 && armed_reg)
                        begin
                            armed_next = 1'b0;
                            cleared    = 1'b1;
                        end
                    end
                end
                CMD_COMPLETION:
                begin
                    if (cur_count != '0)
                    begin
                        found    = 1'b1;
                        count_we = 1'b1;
                        count_wr = count_dec;
                        if (count_dec == '0)
                        begin
                            waiting_next = waiting_dec;
                            if (waiting_dec == '0 && armed_reg)
                            begin
                                armed_next = 1'b0;
                                cleared    = 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        pin_valid_next = pin_valid_reg;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (sel[i] && pin_set)
                pin_valid_next[i] = 1'b1;
            else if (sel[i] && pin_clr)
                pin_valid_next[i] = 1'b0;
        end
    end

    always_comb
    begin
        result.emit_packet     = emit;
        result.found           = found;
        result.barrier_cleared = cleared;
        result.complete        = !armed_next;
        result.teardown_ok     = !armed_next && (pin_valid_next == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg     <= 1'b0;
            waiting_reg   <= '0;
            pin_valid_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
                count_reg[i] <= '0;
        end
        else if (fire)
        begin
            armed_reg     <= armed_next;
            waiting_reg   <= waiting_next;
            pin_valid_reg <= pin_valid_next;
            for (int i = 0; i < SLOTS; i++)
                if (sel[i] && count_we)
                    count_reg[i] <= count_wr;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < SLOTS; i++)
            if (fire && sel[i] && pin_set)
                pin_seq_reg[i] <= sequence_id;
    end

endmodule
